FILE: sv/nsf_pkg.sv
// Shared types and character codes for the NMEA sentence framer.
package nsf_pkg;

   localparam int unsigned MAX_FIELD_BUFFER = 256;
   localparam logic [8:0]  FIELD_BUFFER_RESET = 9'd64;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_PRINT_LO = 8'h20;
   localparam logic [7:0] CH_PRINT_HI = 8'h7E;

   localparam logic [2:0] ST_SYNCING  = 3'd0;
   localparam logic [2:0] ST_DECODING = 3'd1;
   localparam logic [2:0] ST_DECODED  = 3'd2;
   localparam logic [2:0] ST_SKIPPED  = 3'd3;
   localparam logic [2:0] ST_ERROR    = 3'd4;

   localparam logic [2:0] EC_NONE       = 3'd0;
   localparam logic [2:0] EC_PHASE      = 3'd1;
   localparam logic [2:0] EC_NONPRINT   = 3'd2;
   localparam logic [2:0] EC_FORMAT     = 3'd3;
   localparam logic [2:0] EC_MISMATCH   = 3'd4;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       result_slot_free;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  error_cause;
      logic        data_valid;
      logic [7:0]  data_byte;
      logic [7:0]  field_index;
      logic        field_end;
      logic [7:0]  field_length;
      logic        overflow_now;
      logic [7:0]  running_checksum;
      logic [15:0] parse_error_count;
      logic [15:0] crc_error_count;
      logic [15:0] overflow_count;
   } rsp_type;

endpackage

FILE: sv/nsf_cfg.sv
// Field buffer size register and the field capacity derived from it.
module nsf_cfg
   import nsf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [8:0] csr_write_data,
   output logic [7:0] capacity
);

   localparam logic [8:0] SIZE_MAX = 9'(MAX_FIELD_BUFFER);

   logic [8:0] size_ff;
   logic [8:0] size_in;
   logic [8:0] size_clamped;

   always_comb begin
      size_in = csr_write_enable ? csr_write_data : size_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= FIELD_BUFFER_RESET;
      end else begin
         size_ff <= size_in;
      end
   end

   always_comb begin
      priority if (size_ff < 9'd2) begin
         size_clamped = 9'd2;
      end else if (size_ff > SIZE_MAX) begin
         size_clamped = SIZE_MAX;
      end else begin
         size_clamped = size_ff;
      end
   end

   assign capacity = 8'(size_clamped - 9'd1);

endmodule

FILE: sv/nsf_parser.sv
// Sentence parse state and the per-word framing, checksum and error logic.
module nsf_parser
   import nsf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  req_type    req,
   input  logic [7:0] capacity,
   output rsp_type    rsp
);

   localparam logic [2:0] PH_STARTED = 3'b001;
   localparam logic [2:0] PH_CSUM    = 3'b010;
   localparam logic [2:0] PH_CR      = 3'b100;

   logic [2:0]  phase_ff,  phase_in;
   logic [7:0]  field_ff,  field_in;
   logic [7:0]  accum_ff,  accum_in;
   logic [7:0]  fill_ff,   fill_in;
   logic        skip_ff,   skip_in;
   logic [7:0]  hex_ff,    hex_in;
   logic [1:0]  digits_ff, digits_in;
   logic        bad_ff,    bad_in;
   logic [15:0] perr_ff,   perr_in;
   logic [15:0] cerr_ff,   cerr_in;
   logic [15:0] ovf_ff,    ovf_in;

   logic [7:0] b;
   logic       is_hex;
   logic [3:0] hex_nib;
   logic       stored;

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v != 16'hFFFF) ? v + 16'd1 : v;
   endfunction

   assign b = req.rx_byte;

   always_comb begin
      is_hex  = 1'b1;
      hex_nib = 4'd0;
      priority if (b >= 8'h30 && b <= 8'h39) begin
         hex_nib = 4'(b - 8'h30);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         hex_nib = 4'(b - 8'h37);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         hex_nib = 4'(b - 8'h57);
      end else begin
         is_hex = 1'b0;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      field_in  = field_ff;
      accum_in  = accum_ff;
      fill_in   = fill_ff;
      skip_in   = skip_ff;
      hex_in    = hex_ff;
      digits_in = digits_ff;
      bad_in    = bad_ff;
      perr_in   = perr_ff;
      cerr_in   = cerr_ff;
      ovf_in    = ovf_ff;
      stored    = 1'b1;

      rsp = '0;
      rsp.status      = ST_DECODING;
      rsp.error_cause = EC_NONE;
      rsp.field_index = field_ff;

      priority if (phase_ff == 3'b000 && b != CH_DOLLAR) begin
         rsp.status = ST_SYNCING;
      end else if (b == CH_DOLLAR) begin
         phase_in  = PH_STARTED;
         field_in  = 8'd0;
         accum_in  = 8'd0;
         fill_in   = 8'd0;
         skip_in   = ~req.result_slot_free;
         hex_in    = 8'd0;
         digits_in = 2'd0;
         bad_in    = 1'b0;
         rsp.field_index = 8'd0;
      end else if (b == CH_COMMA || b == CH_STAR) begin
         if (phase_ff != PH_STARTED) begin
            rsp.status      = ST_ERROR;
            rsp.error_cause = EC_PHASE;
         end else begin
            rsp.field_end    = 1'b1;
            rsp.field_length = fill_ff;
            fill_in          = 8'd0;
            if (b == CH_COMMA) begin
               accum_in = accum_ff ^ b;
               if (field_ff != 8'hFF) begin
                  field_in = field_ff + 8'd1;
               end
            end else begin
               phase_in  = phase_ff | PH_CSUM;
               hex_in    = 8'd0;
               digits_in = 2'd0;
               bad_in    = 1'b0;
            end
         end
      end else if (b == CH_CR) begin
         priority if ((phase_ff & PH_CR) != 3'b000) begin
            perr_in         = sat_inc(perr_ff);
            rsp.status      = ST_ERROR;
            rsp.error_cause = EC_FORMAT;
         end else if ((phase_ff & PH_CSUM) != 3'b000) begin
            priority if (bad_ff || digits_ff != 2'd2) begin
               perr_in         = sat_inc(perr_ff);
               rsp.status      = ST_ERROR;
               rsp.error_cause = EC_FORMAT;
            end else if (hex_ff != accum_ff) begin
               cerr_in         = sat_inc(cerr_ff);
               rsp.status      = ST_ERROR;
               rsp.error_cause = EC_MISMATCH;
            end else begin
               phase_in = phase_ff | PH_CR;
            end
         end else if (phase_ff != PH_STARTED) begin
            rsp.status      = ST_ERROR;
            rsp.error_cause = EC_PHASE;
         end else begin
            rsp.field_end    = 1'b1;
            rsp.field_length = fill_ff;
            phase_in         = phase_ff | PH_CR;
         end
      end else if (b == CH_LF) begin
         if ((phase_ff & (PH_STARTED | PH_CR)) != (PH_STARTED | PH_CR)) begin
            perr_in         = sat_inc(perr_ff);
            rsp.status      = ST_ERROR;
            rsp.error_cause = EC_FORMAT;
         end else begin
            phase_in   = 3'b000;
            rsp.status = skip_ff ? ST_SKIPPED : ST_DECODED;
         end
      end else if (b < CH_PRINT_LO || b > CH_PRINT_HI) begin
         rsp.status      = ST_ERROR;
         rsp.error_cause = EC_NONPRINT;
      end else begin
         if (fill_ff >= capacity) begin
            ovf_in           = sat_inc(ovf_ff);
            skip_in          = 1'b1;
            rsp.overflow_now = 1'b1;
            stored           = 1'b0;
         end
         if (phase_ff == PH_STARTED) begin
            accum_in = accum_ff ^ b;
            if (stored) begin
               rsp.data_valid = 1'b1;
               rsp.data_byte  = b;
            end
         end else if ((phase_ff & (PH_CSUM | PH_CR)) == PH_CSUM) begin
            if (!is_hex || digits_ff == 2'd2) begin
               bad_in = 1'b1;
            end else begin
               hex_in    = {hex_ff[3:0], hex_nib};
               digits_in = digits_ff + 2'd1;
            end
         end
         if (stored) begin
            fill_in = fill_ff + 8'd1;
         end
      end

      if (rsp.status == ST_ERROR) begin
         phase_in = 3'b000;
      end

      rsp.running_checksum  = accum_in;
      rsp.parse_error_count = perr_in;
      rsp.crc_error_count   = cerr_in;
      rsp.overflow_count    = ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= 3'b000;
         field_ff  <= 8'd0;
         accum_ff  <= 8'd0;
         fill_ff   <= 8'd0;
         skip_ff   <= 1'b1;
         hex_ff    <= 8'd0;
         digits_ff <= 2'd0;
         bad_ff    <= 1'b0;
         perr_ff   <= 16'd0;
         cerr_ff   <= 16'd0;
         ovf_ff    <= 16'd0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         field_ff  <= field_in;
         accum_ff  <= accum_in;
         fill_ff   <= fill_in;
         skip_ff   <= skip_in;
         hex_ff    <= hex_in;
         digits_ff <= digits_in;
         bad_ff    <= bad_in;
         perr_ff   <= perr_in;
         cerr_ff   <= cerr_in;
         ovf_ff    <= ovf_in;
      end
   end

   a_error_hunts: assert property (@(posedge clock) disable iff (reset)
      step_en && rsp.status == ST_ERROR |=> phase_ff == 3'b000)
      else $error("phase not cleared after error");

   a_overflow_skips: assert property (@(posedge clock) disable iff (reset)
      step_en && rsp.overflow_now |=> skip_ff)
      else $error("sentence not marked skipped after overflow");

   a_field_end_started: assert property (@(posedge clock) disable iff (reset)
      step_en && rsp.field_end |=> phase_ff[0] && phase_ff != PH_STARTED
         || $past(b) == CH_COMMA)
      else $error("field close left wrong phase");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      step_en && rsp.data_valid |=> fill_ff != 8'd0 && $past(fill_ff) < $past(capacity))
      else $error("byte stored into a full field");

endmodule

FILE: sv/nmea_sentence_framer_top.sv
// Top level of the NMEA sentence framer: word registers, config and parser.
//
// One word in per received byte on req_*, one status word out on rsp_*.
// Each rsp word carries the status, error cause, passed field character,
// field index and end marks, running checksum and the three error counters.
// A byte lands in the input register at the edge that accepts it; the parser
// works on it from that register and, once the output register can advance,
// the result lands in the output register, where rsp_valid rises.
// Throughput is one byte per cycle while rsp_stall is low; the parse state
// updates in one pass of logic between the input and output registers.
// When rsp_stall is high the output register holds its word and the input
// register may still take one more byte; req_stall rises once both are full.
// csr_write_enable loads the field buffer size (reset 64); write it only
// while no word is in flight.
// Synchronous reset returns the parser to hunting for '$', clears all
// counters and the checksum, and empties both word registers.
module nmea_sentence_framer_top
   import nsf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_write_enable,
   input  logic [8:0] csr_write_data
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff,  in_data_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff,  rsp_data_in;

   logic       advance;
   logic       load_in;
   logic       step_en;
   logic [7:0] capacity;
   rsp_type    step_rsp;

   assign advance   = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = in_valid_ff & ~advance;
   assign load_in   = req_valid & ~req_stall;
   assign step_en   = in_valid_ff & advance;

   nsf_cfg u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .capacity         (capacity)
   );

   nsf_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .step_en  (step_en),
      .req      (in_data_ff),
      .capacity (capacity),
      .rsp      (step_rsp)
   );

   always_comb begin
      in_valid_in  = load_in | (in_valid_ff & ~advance);
      in_data_in   = load_in ? req_data : in_data_ff;
      rsp_valid_in = step_en | (rsp_valid_ff & rsp_stall);
      rsp_data_in  = step_en ? step_rsp : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
